>>> rtl/core/pcf_pkg.sv
// pcf_pkg: shared types, constants and the crc byte fold for the png chunk framer
// no dependencies
package pcf_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] TYPE_RESET = 32'h7072_4976;

    localparam logic [1:0] KIND_LEN  = 2'd0;
    localparam logic [1:0] KIND_TYPE = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;
    localparam logic [1:0] KIND_CRC  = 2'd3;

    // byte positions within one item's output sequence
    localparam logic [3:0] POS_LEN0  = 4'd0;
    localparam logic [3:0] POS_LEN3  = 4'd3;
    localparam logic [3:0] POS_TYPE0 = 4'd4;
    localparam logic [3:0] POS_TYPE3 = 4'd7;
    localparam logic [3:0] POS_DATA  = 4'd8;
    localparam logic [3:0] POS_CRC0  = 4'd9;
    localparam logic [3:0] POS_CRC3  = 4'd12;

    typedef struct packed {
        logic       valid;
        logic [3:0] pos;
    } pos_step_t;

    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/pcf_if.sv
// pcf_if: valid/ready channel interfaces for payload items and framed bytes
// depends on nothing
interface pcf_payload_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        has_data;
    logic        is_last;
    logic [30:0] chunk_length;

    modport source (output valid, output data_byte, output has_data, output is_last,
                    output chunk_length, input ready);
    modport sink   (input valid, input data_byte, input has_data, input is_last,
                    input chunk_length, output ready);
endinterface

interface pcf_framed_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       out_last;

    modport source (output valid, output out_byte, output out_kind, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_kind, input out_last,
                    output ready);
endinterface

>>> rtl/core/png_chunk_framer.sv
// png_chunk_framer: frames png chunks (length, type, data, crc-32) from payload items
// depends on pcf_pkg and the channel interfaces in pcf_if.sv
//
// usage:
//   payload carries one item per handshake: a data byte with has_data, is_last and
//   chunk_length (read on the first item of a chunk only). framed carries one byte per
//   handshake with its kind (length, type, data, crc) and a last flag on the final
//   crc byte. cfg_we/cfg_wdata write the four type bytes, used from the next header.
//   an accepted item sits in an item register and is serialized into the output
//   register, one byte per cycle unless the receiver stalls: a mid-chunk data item
//   sends its data byte; an opening item sends length and type bytes, then data if
//   it has any; a closing item then sends the four crc bytes.
//   the next item is accepted in the cycle the current item's final byte moves to the
//   output register. a stalled receiver holds the output register and, behind it,
//   the item register; nothing is dropped. reset clears valid flags, sets the crc to
//   all ones, leaves the block outside a chunk and the type register at "prIv".
module png_chunk_framer
    import pcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    pcf_payload_if.sink        payload,
    pcf_framed_if.source       framed,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata
);

    logic [31:0] chunk_type_reg;
    logic [31:0] crc_reg, crc_next;
    logic        inside_reg, inside_next;

    logic        slot_valid_reg, slot_valid_next;
    logic [3:0]  pos_reg, pos_next;
    logic        hdr_reg, hd_reg, il_reg;
    logic [7:0]  data_reg;
    logic [30:0] len_reg;
    logic [31:0] type_reg;

    logic        ovalid_reg, ovalid_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic [1:0]  okind_reg, okind_next;
    logic        olast_reg, olast_next;

    logic        fire, accept, in_hdr;
    pos_step_t   step, first;
    logic [7:0]  cur_byte;
    logic [1:0]  cur_kind;
    logic [31:0] fin;

    function automatic pos_step_t next_after(input logic [3:0] p, input logic hdr,
                                             input logic hd, input logic il);
        pos_step_t r;
        r.valid = 1'b0;
        r.pos   = POS_LEN0;
        if (hdr && p < POS_TYPE3) begin
            r.valid = 1'b1;
            r.pos   = p + 4'd1;
        end else if (hd && p < POS_DATA) begin
            r.valid = 1'b1;
            r.pos   = POS_DATA;
        end else if (il && p < POS_CRC0) begin
            r.valid = 1'b1;
            r.pos   = POS_CRC0;
        end else if (p >= POS_CRC0 && p < POS_CRC3) begin
            r.valid = 1'b1;
            r.pos   = p + 4'd1;
        end
        return r;
    endfunction

    assign fin    = crc_reg ^ CRC_ONES;
    assign in_hdr = !inside_reg;
    assign fire   = slot_valid_reg && (!ovalid_reg || framed.ready);
    assign step   = next_after(pos_reg, hdr_reg, hd_reg, il_reg);

    assign payload.ready = !slot_valid_reg || (fire && !step.valid);
    assign accept        = payload.valid && payload.ready;

    always_comb
    begin
        first.valid = 1'b1;
        first.pos   = POS_LEN0;
        if (in_hdr) begin
            first.pos = POS_LEN0;
        end else if (payload.has_data) begin
            first.pos = POS_DATA;
        end else if (payload.is_last) begin
            first.pos = POS_CRC0;
        end else begin
            first.valid = 1'b0;
        end
    end

    always_comb
    begin
        cur_byte = data_reg;
        cur_kind = KIND_DATA;
        case (pos_reg)
            4'd0:    begin cur_byte = {1'b0, len_reg[30:24]}; cur_kind = KIND_LEN; end
            4'd1:    begin cur_byte = len_reg[23:16];         cur_kind = KIND_LEN; end
            4'd2:    begin cur_byte = len_reg[15:8];          cur_kind = KIND_LEN; end
            4'd3:    begin cur_byte = len_reg[7:0];           cur_kind = KIND_LEN; end
            4'd4:    begin cur_byte = type_reg[31:24];        cur_kind = KIND_TYPE; end
            4'd5:    begin cur_byte = type_reg[23:16];        cur_kind = KIND_TYPE; end
            4'd6:    begin cur_byte = type_reg[15:8];         cur_kind = KIND_TYPE; end
            4'd7:    begin cur_byte = type_reg[7:0];          cur_kind = KIND_TYPE; end
            4'd9:    begin cur_byte = fin[31:24];             cur_kind = KIND_CRC; end
            4'd10:   begin cur_byte = fin[23:16];             cur_kind = KIND_CRC; end
            4'd11:   begin cur_byte = fin[15:8];              cur_kind = KIND_CRC; end
            4'd12:   begin cur_byte = fin[7:0];               cur_kind = KIND_CRC; end
            default: begin cur_byte = data_reg;               cur_kind = KIND_DATA; end
        endcase
    end

    always_comb
    begin
        crc_next        = crc_reg;
        inside_next     = inside_reg;
        slot_valid_next = slot_valid_reg;
        pos_next        = pos_reg;
        ovalid_next     = ovalid_reg && !framed.ready;
        obyte_next      = obyte_reg;
        okind_next      = okind_reg;
        olast_next      = olast_reg;

        if (fire) begin
            ovalid_next = 1'b1;
            obyte_next  = cur_byte;
            okind_next  = cur_kind;
            olast_next  = (pos_reg == POS_CRC3);
            case (pos_reg) inside
                [POS_TYPE0:POS_DATA]: crc_next = crc_fold(crc_reg, cur_byte);
                POS_CRC3:             crc_next = CRC_ONES;
                default:              crc_next = crc_reg;
            endcase
            slot_valid_next = step.valid;
            pos_next        = step.pos;
        end

        if (accept) begin
            inside_next     = !payload.is_last;
            slot_valid_next = first.valid;
            pos_next        = first.pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            chunk_type_reg <= TYPE_RESET;
            crc_reg        <= CRC_ONES;
            inside_reg     <= 1'b0;
            slot_valid_reg <= 1'b0;
            pos_reg        <= POS_LEN0;
            ovalid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                chunk_type_reg <= cfg_wdata;
            end
            crc_reg        <= crc_next;
            inside_reg     <= inside_next;
            slot_valid_reg <= slot_valid_next;
            pos_reg        <= pos_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    // item and output payload registers
    always_ff @(posedge clk)
    begin
        if (accept) begin
            hdr_reg  <= in_hdr;
            hd_reg   <= payload.has_data;
            il_reg   <= payload.is_last;
            data_reg <= payload.data_byte;
            len_reg  <= payload.chunk_length;
            type_reg <= chunk_type_reg;
        end
        obyte_reg <= obyte_next;
        okind_reg <= okind_next;
        olast_reg <= olast_next;
    end

    assign framed.valid    = ovalid_reg;
    assign framed.out_byte = obyte_reg;
    assign framed.out_kind = okind_reg;
    assign framed.out_last = olast_reg;

endmodule
